/* src/tlfo_pkg.sv */
// package of shared types, constants and widths for the tremolo triangle lfo
`default_nettype none
package tlfo_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int COUNT_WIDTH  = 17;

	localparam int DEPTH_W = 16;
	localparam int QP_W    = 16;
	localparam int INV_W   = 25;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// gain is Q2.15 in [-1, 1]
	localparam int G_W = 17;
	// modulation factor (1-d)*2^30 + d*g*2^30 stays within [-2^30, 2^30]
	localparam int M_W = 32;

	localparam int A_W = (COUNT_WIDTH > SAMPLE_WIDTH) ?
		((COUNT_WIDTH > G_W) ? COUNT_WIDTH : G_W) :
		((SAMPLE_WIDTH > G_W) ? SAMPLE_WIDTH : G_W);
	localparam int B_W = M_W + 1;
	localparam int P_W = A_W + B_W;

	localparam int CMP_W = ((COUNT_WIDTH > QP_W + 1) ? COUNT_WIDTH : QP_W + 1) + 1;

	localparam logic [DEPTH_W-1:0] DEPTH_ONE   = 16'd32768;
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd16384;
	localparam logic [QP_W-1:0]    QP_RESET    = 16'd11025;
	localparam logic [INV_W-1:0]   INV_RESET   = 25'd1522;

	localparam logic signed [P_W-1:0] G_BIAS = P_W'(64'sd256);
	localparam logic signed [P_W-1:0] G_MAX  = P_W'(64'sd32768);
	localparam logic signed [P_W-1:0] G_MIN  = -G_MAX;
	localparam logic signed [P_W-1:0] Y_BIAS = P_W'(64'sd1 <<< 29);
	localparam logic signed [P_W-1:0] S_MAX  = P_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [P_W-1:0] S_MIN  = -S_MAX - P_W'(64'sd1);

	typedef enum logic [1:0] {
		REG_DEPTH = 2'd0,
		REG_QP    = 2'd1,
		REG_INV   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_G,
		ST_MUL_Y,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SEL_P,
		SEL_G,
		SEL_Y
	} mul_sel_t;

	typedef struct packed {
		logic             load_x;
		logic             mul_en;
		mul_sel_t         mul_sel;
		logic             load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [QP_W-1:0]    qp;
		logic [INV_W-1:0]   inv;
		logic               qp_wr;
		logic [QP_W-1:0]    qp_new;
	} cfg_t;

endpackage
`default_nettype wire

/* src/tlfo_regs.sv */
// configuration registers behind the apb-style port
`default_nettype none
module tlfo_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tlfo_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [tlfo_pkg::DATA_W-1:0]  pwdata,
	output logic      [tlfo_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	output tlfo_pkg::cfg_t                    cfg
);

	logic [tlfo_pkg::DEPTH_W-1:0] depth_q;
	logic [tlfo_pkg::QP_W-1:0]    qp_q;
	logic [tlfo_pkg::INV_W-1:0]   inv_q;
	logic                         wr;
	tlfo_pkg::reg_idx_t           idx;
	logic [tlfo_pkg::DEPTH_W-1:0] depth_new;
	logic [tlfo_pkg::QP_W-1:0]    qp_new;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = tlfo_pkg::reg_idx_t'(paddr[3:2]);

	assign depth_new = (pwdata[15:0] > tlfo_pkg::DEPTH_ONE) ? tlfo_pkg::DEPTH_ONE
		: pwdata[15:0];
	assign qp_new = (pwdata[15:0] == '0) ? tlfo_pkg::QP_W'(1) : pwdata[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= tlfo_pkg::DEPTH_RESET;
			qp_q    <= tlfo_pkg::QP_RESET;
			inv_q   <= tlfo_pkg::INV_RESET;
		end else if (wr) begin
			case (idx)
				tlfo_pkg::REG_DEPTH: depth_q <= depth_new;
				tlfo_pkg::REG_QP:    qp_q    <= qp_new;
				tlfo_pkg::REG_INV:   inv_q   <= pwdata[24:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tlfo_pkg::REG_DEPTH: prdata = tlfo_pkg::DATA_W'(depth_q);
			tlfo_pkg::REG_QP:    prdata = tlfo_pkg::DATA_W'(qp_q);
			tlfo_pkg::REG_INV:   prdata = tlfo_pkg::DATA_W'(inv_q);
			default:             prdata = '0;
		endcase
	end

	assign cfg.depth  = depth_q;
	assign cfg.qp     = qp_q;
	assign cfg.inv    = inv_q;
	assign cfg.qp_wr  = wr && (idx == tlfo_pkg::REG_QP);
	assign cfg.qp_new = qp_new;

endmodule
`default_nettype wire

/* src/tlfo_ctrl.sv */
// sequencer that steps the shared multiplier through one item
`default_nettype none
module tlfo_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire tlfo_pkg::dp_sts_t sts,
	output tlfo_pkg::dp_cmd_t      cmd
);

	tlfo_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlfo_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt    = state_q;
		in_ready     = 1'b0;
		cmd.load_x   = 1'b0;
		cmd.mul_en   = 1'b0;
		cmd.mul_sel  = tlfo_pkg::SEL_P;
		cmd.load_out = 1'b0;
		case (state_q)
			tlfo_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_x = 1'b1;
					state_nxt  = tlfo_pkg::ST_MUL_P;
				end
			end
			tlfo_pkg::ST_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tlfo_pkg::SEL_P;
				state_nxt   = tlfo_pkg::ST_MUL_G;
			end
			tlfo_pkg::ST_MUL_G: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tlfo_pkg::SEL_G;
				state_nxt   = tlfo_pkg::ST_MUL_Y;
			end
			tlfo_pkg::ST_MUL_Y: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tlfo_pkg::SEL_Y;
				state_nxt   = tlfo_pkg::ST_DONE;
			end
			tlfo_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					in_ready     = 1'b1;
					if (in_valid) begin
						cmd.load_x = 1'b1;
						state_nxt  = tlfo_pkg::ST_MUL_P;
					end else begin
						state_nxt = tlfo_pkg::ST_IDLE;
					end
				end
			end
			default: state_nxt = tlfo_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* src/tlfo_dp.sv */
// datapath: lfo state, shared multiplier, rounding and output register
`default_nettype none
module tlfo_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire tlfo_pkg::cfg_t                        cfg,
	input  wire tlfo_pkg::dp_cmd_t                     cmd,
	output tlfo_pkg::dp_sts_t                          sts,
	input  wire logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0] sample_in,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0]   sample_out
);

	logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0] x_q;
	logic signed [tlfo_pkg::COUNT_WIDTH-1:0]  count_q;
	logic                                     falling_q;
	logic signed [tlfo_pkg::P_W-1:0]          prod_q;
	logic                                     out_valid_q;
	logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0] sample_out_q;

	logic signed [tlfo_pkg::A_W-1:0]   mul_a;
	logic signed [tlfo_pkg::B_W-1:0]   mul_b;
	logic signed [tlfo_pkg::P_W-1:0]   g_round;
	logic signed [tlfo_pkg::G_W-1:0]   g_sat;
	logic [tlfo_pkg::DEPTH_W:0]        one_minus_d;
	logic signed [tlfo_pkg::M_W-1:0]   m_val;
	logic signed [tlfo_pkg::P_W-1:0]   y_round;
	logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0] y_sat;
	logic signed [tlfo_pkg::CMP_W-1:0] count_x;
	logic signed [tlfo_pkg::CMP_W-1:0] q_x;
	logic signed [tlfo_pkg::CMP_W-1:0] qn_x;
	logic signed [tlfo_pkg::CMP_W-1:0] clamp_x;
	logic                              falling_nxt;

	// gain from the count product, Q2.15
	always_comb begin
		g_round = (prod_q + tlfo_pkg::G_BIAS) >>> 9;
		if (g_round > tlfo_pkg::G_MAX) begin
			g_sat = tlfo_pkg::G_W'(tlfo_pkg::G_MAX);
		end else if (g_round < tlfo_pkg::G_MIN) begin
			g_sat = tlfo_pkg::G_W'(tlfo_pkg::G_MIN);
		end else begin
			g_sat = tlfo_pkg::G_W'(g_round);
		end
	end

	assign one_minus_d = {1'b0, tlfo_pkg::DEPTH_ONE} - {1'b0, cfg.depth};
	assign m_val = signed'({one_minus_d, 15'b0}) + tlfo_pkg::M_W'(prod_q);

	always_comb begin
		case (cmd.mul_sel)
			tlfo_pkg::SEL_P: begin
				mul_a = tlfo_pkg::A_W'(count_q);
				mul_b = tlfo_pkg::B_W'(signed'({1'b0, cfg.inv}));
			end
			tlfo_pkg::SEL_G: begin
				mul_a = tlfo_pkg::A_W'(g_sat);
				mul_b = tlfo_pkg::B_W'(signed'({1'b0, cfg.depth}));
			end
			tlfo_pkg::SEL_Y: begin
				mul_a = tlfo_pkg::A_W'(x_q);
				mul_b = tlfo_pkg::B_W'(m_val);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round half up and saturate the final product
	always_comb begin
		y_round = (prod_q + tlfo_pkg::Y_BIAS) >>> 30;
		if (y_round > tlfo_pkg::S_MAX) begin
			y_sat = tlfo_pkg::SAMPLE_WIDTH'(tlfo_pkg::S_MAX);
		end else if (y_round < tlfo_pkg::S_MIN) begin
			y_sat = tlfo_pkg::SAMPLE_WIDTH'(tlfo_pkg::S_MIN);
		end else begin
			y_sat = tlfo_pkg::SAMPLE_WIDTH'(y_round);
		end
	end

	// lfo direction and limit clamp
	always_comb begin
		count_x = tlfo_pkg::CMP_W'(count_q);
		q_x     = signed'(tlfo_pkg::CMP_W'(cfg.qp));
		qn_x    = signed'(tlfo_pkg::CMP_W'(cfg.qp_new));
		if (count_x >= q_x) begin
			falling_nxt = 1'b1;
		end else if (count_x <= -q_x) begin
			falling_nxt = 1'b0;
		end else begin
			falling_nxt = falling_q;
		end
		if (count_x > qn_x) begin
			clamp_x = qn_x;
		end else if (count_x < -qn_x) begin
			clamp_x = -qn_x;
		end else begin
			clamp_x = count_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			falling_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.qp_wr) begin
				count_q <= tlfo_pkg::COUNT_WIDTH'(clamp_x);
			end else if (cmd.load_out) begin
				falling_q <= falling_nxt;
				count_q   <= falling_nxt ? count_q - tlfo_pkg::COUNT_WIDTH'(1)
					: count_q + tlfo_pkg::COUNT_WIDTH'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= sample_in;
		end
		if (cmd.mul_en) begin
			prod_q <= tlfo_pkg::P_W'(mul_a) * tlfo_pkg::P_W'(mul_b);
		end
		if (cmd.load_out) begin
			sample_out_q <= y_sat;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign sample_out   = sample_out_q;

endmodule
`default_nettype wire

/* src/tremolo_triangle_lfo.sv */
// top level of the tremolo effect with a triangle lfo
//
// usage:
//   in channel: in_valid / in_ready carry one signed sample_in per item.
//   out channel: out_valid / out_ready carry one sample_out per input item.
//   config: apb-style port, depth at 0x0, quarter_period at 0x4,
//   inv_quarter_period at 0x8, pready always high, reads return the value.
// timing:
//   an accepted item passes three multiply steps on one shared multiplier
//   (lfo gain, depth scaling, sample scaling) and then enters the output
//   register once that is free. the next item is taken in that same
//   cycle, so the block takes no new item while the steps run.
// reset:
//   registers return to depth 0.5, quarter_period 11025, reciprocal 1522,
//   the lfo count clears and counts upward; no result is pending.
// stall:
//   a finished result waits in the output register; a further item still
//   runs through the multiplier and then holds until the output is taken.
`default_nettype none
module tremolo_triangle_lfo (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [tlfo_pkg::ADDR_W-1:0]           paddr,
	input  wire logic [tlfo_pkg::DATA_W-1:0]           pwdata,
	output logic      [tlfo_pkg::DATA_W-1:0]           prdata,
	output logic                                       pready,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0] sample_in,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0]   sample_out
);

	tlfo_pkg::cfg_t    cfg;
	tlfo_pkg::dp_cmd_t cmd;
	tlfo_pkg::dp_sts_t sts;

	tlfo_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tlfo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlfo_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.sts        (sts),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("item accepted while multiply steps in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("pending result overwritten");

	a_mul_not_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en |-> !in_ready)
		else $error("multiplier busy while input ready");
`endif

endmodule
`default_nettype wire

/* bench/tremolo_triangle_lfo_tb.sv */
// testbench for the tremolo triangle lfo: directed and random samples checked against a predictor
module tremolo_triangle_lfo_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int STALL_LIMIT    = 4000;
	localparam int HOLDOFF_CYCLES = 150;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_ITEMS    = 160;
	localparam int PHASES         = 8;
	localparam int PRESSURE_PHASE = 4;
	localparam int CORNERS        = 7;
	localparam int PRINT_CAP      = 40;

	localparam longint GAIN_ONE   = 32768;
	localparam longint SAMPLE_HI  = (longint'(1) <<< (tlfo_pkg::SAMPLE_WIDTH - 1)) - 1;
	localparam longint SAMPLE_LO  = -SAMPLE_HI - 1;

	localparam logic [tlfo_pkg::ADDR_W-1:0] ADDR_DEPTH =
		tlfo_pkg::ADDR_W'(4 * int'(tlfo_pkg::REG_DEPTH));
	localparam logic [tlfo_pkg::ADDR_W-1:0] ADDR_QP =
		tlfo_pkg::ADDR_W'(4 * int'(tlfo_pkg::REG_QP));
	localparam logic [tlfo_pkg::ADDR_W-1:0] ADDR_INV =
		tlfo_pkg::ADDR_W'(4 * int'(tlfo_pkg::REG_INV));
	localparam logic [tlfo_pkg::ADDR_W-1:0] ADDR_SPARE = tlfo_pkg::ADDR_W'(12);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [tlfo_pkg::ADDR_W-1:0] paddr = '0;
	logic [tlfo_pkg::DATA_W-1:0] pwdata = '0;
	wire  [tlfo_pkg::DATA_W-1:0] prdata;
	wire  pready;
	logic in_valid = 1'b0;
	wire  in_ready;
	logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0] sample_in = '0;
	wire  out_valid;
	logic out_ready = 1'b0;
	wire  signed [tlfo_pkg::SAMPLE_WIDTH-1:0] sample_out;

	// predictor state and register copies
	longint gain_depth = longint'(tlfo_pkg::DEPTH_RESET);
	longint lfo_limit = longint'(tlfo_pkg::QP_RESET);
	longint lfo_recip = longint'(tlfo_pkg::INV_RESET);
	longint lfo_count = 0;
	bit lfo_falling = 1'b0;

	logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0] samples_to_send[$];
	logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0] expected_samples[$];

	int src_idle_pct = 0;
	int rcv_stall_pct = 0;
	bit holdoff_req = 1'b0;
	int holdoff_left = 0;
	bit in_fire = 1'b0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int results_checked = 0;
	int items_sent = 0;
	int settings_written = 0;

	tremolo_triangle_lfo u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out)
	);

	always #CLK_HALF clk = ~clk;

	function automatic logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0] corner_sample(int k);
		case (k)
			0: return '0;
			1: return {1'b0, {(tlfo_pkg::SAMPLE_WIDTH-1){1'b1}}};
			2: return {1'b1, {(tlfo_pkg::SAMPLE_WIDTH-1){1'b0}}};
			3: return tlfo_pkg::SAMPLE_WIDTH'(1);
			4: return '1;
			5: return {(tlfo_pkg::SAMPLE_WIDTH/2){2'b01}};
			default: return {(tlfo_pkg::SAMPLE_WIDTH/2){2'b10}};
		endcase
	endfunction

	function automatic void apply_reg_write(logic [tlfo_pkg::ADDR_W-1:0] addr,
		logic [tlfo_pkg::DATA_W-1:0] data);
		case (addr)
			ADDR_DEPTH: begin
				gain_depth = (data[tlfo_pkg::DEPTH_W-1:0] > tlfo_pkg::DEPTH_ONE) ?
					tlfo_pkg::DEPTH_ONE : data[tlfo_pkg::DEPTH_W-1:0];
			end
			ADDR_QP: begin
				lfo_limit = (data[tlfo_pkg::QP_W-1:0] == '0) ? 1 : data[tlfo_pkg::QP_W-1:0];
				if (lfo_count > lfo_limit)
					lfo_count = lfo_limit;
				else if (lfo_count < -lfo_limit)
					lfo_count = -lfo_limit;
			end
			ADDR_INV: lfo_recip = data[tlfo_pkg::INV_W-1:0];
			default: ;
		endcase
	endfunction

	// gain from the count before the step, then the triangle moves one sample
	function automatic logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0] tremolo_step(
		logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0] x
	);
		longint xs, prod, gain, acc, y;
		logic signed [tlfo_pkg::COUNT_WIDTH-1:0] wrapped;
		xs = x;
		prod = lfo_count * lfo_recip;
		gain = (prod + 256) >>> 9;
		if (gain > GAIN_ONE)
			gain = GAIN_ONE;
		else if (gain < -GAIN_ONE)
			gain = -GAIN_ONE;
		acc = xs * (GAIN_ONE - gain_depth) * GAIN_ONE + xs * gain_depth * gain;
		y = (acc + (longint'(1) <<< 29)) >>> 30;
		if (y > SAMPLE_HI)
			y = SAMPLE_HI;
		else if (y < SAMPLE_LO)
			y = SAMPLE_LO;
		if (lfo_count >= lfo_limit)
			lfo_falling = 1'b1;
		else if (lfo_count <= -lfo_limit)
			lfo_falling = 1'b0;
		wrapped = tlfo_pkg::COUNT_WIDTH'(lfo_falling ? lfo_count - 1 : lfo_count + 1);
		lfo_count = wrapped;
		return tlfo_pkg::SAMPLE_WIDTH'(y);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatches < PRINT_CAP)
			$display("%0t mismatch: %s, got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic write_reg(logic [tlfo_pkg::ADDR_W-1:0] addr,
		logic [tlfo_pkg::DATA_W-1:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		apply_reg_write(addr, data);
		settings_written++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic drain();
		while (samples_to_send.size() != 0 || in_valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (samples_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				in_valid <= 1'b1;
				sample_in <= samples_to_send.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with a long hold-off on request
	always @(negedge clk) begin
		if (holdoff_req) begin
			holdoff_left = HOLDOFF_CYCLES;
			holdoff_req = 1'b0;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// monitor: check the output first, then predict the item taken at this edge
	always @(posedge clk) begin
		logic signed [tlfo_pkg::SAMPLE_WIDTH-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				report_mismatch("output with no sample pending", sample_out, 0);
			end else begin
				want = expected_samples.pop_front();
				results_checked++;
				if (sample_out !== want)
					report_mismatch("sample_out", sample_out, want);
			end
		end
		in_fire <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			expected_samples.push_back(tremolo_step(sample_in));
			items_sent++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("[tremolo_triangle_lfo] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int r;
		logic [tlfo_pkg::DATA_W-1:0] qp_pick, qp_eff, inv_pick, depth_pick;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, corner samples
		@(posedge clk);
		for (int k = 0; k < CORNERS; k++)
			samples_to_send.push_back(corner_sample(k));
		drain();

		// full depth, unit limit, exact reciprocal: gain swings through +1, 0, -1
		write_reg(ADDR_DEPTH, 32'h0000_ffff);
		write_reg(ADDR_QP, 32'd1);
		write_reg(ADDR_INV, 32'h0100_0000);
		@(posedge clk);
		repeat (4) samples_to_send.push_back(corner_sample(2));
		repeat (2) samples_to_send.push_back(corner_sample(1));
		drain();

		// zero depth, zero limit, oversized reciprocal, unmapped register
		write_reg(ADDR_DEPTH, 32'd0);
		write_reg(ADDR_QP, 32'd0);
		write_reg(ADDR_INV, 32'h01ff_ffff);
		write_reg(ADDR_SPARE, 32'hffff_ffff);
		@(posedge clk);
		samples_to_send.push_back(corner_sample(1));
		samples_to_send.push_back(corner_sample(2));
		samples_to_send.push_back(tlfo_pkg::SAMPLE_WIDTH'(12345));
		drain();

		// widest limit, then a zero reciprocal
		write_reg(ADDR_DEPTH, 32'd32768);
		write_reg(ADDR_QP, 32'h0000_ffff);
		write_reg(ADDR_INV, 32'd256);
		@(posedge clk);
		samples_to_send.push_back(corner_sample(1));
		samples_to_send.push_back(corner_sample(6));
		drain();
		write_reg(ADDR_INV, 32'd0);
		@(posedge clk);
		samples_to_send.push_back(corner_sample(2));
		samples_to_send.push_back(corner_sample(5));
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			r = $urandom_range(99);
			if (r < 60)
				qp_pick = $urandom_range(6, 0);
			else if (r < 85)
				qp_pick = $urandom_range(400, 7);
			else
				qp_pick = $urandom_range(65535, 1);
			qp_eff = (qp_pick == 0) ? 1 : qp_pick;
			r = $urandom_range(99);
			if (r < 75)
				inv_pick = ((32'd1 << 24) + qp_eff / 2) / qp_eff;
			else if (r < 85)
				inv_pick = $urandom & 32'h01ff_ffff;
			else if (r < 92)
				inv_pick = 0;
			else
				inv_pick = 32'd1 << 24;
			r = $urandom_range(99);
			if (r < 20)
				depth_pick = 0;
			else if (r < 40)
				depth_pick = 32768;
			else if (r < 50)
				depth_pick = $urandom_range(65535, 32769);
			else
				depth_pick = $urandom_range(32767, 0);
			write_reg(ADDR_DEPTH, ($urandom & 32'hffff_0000) | depth_pick);
			write_reg(ADDR_QP, ($urandom & 32'hffff_0000) | qp_pick);
			write_reg(ADDR_INV, ($urandom & 32'hfe00_0000) | inv_pick);
			if ($urandom_range(1) == 1)
				write_reg(ADDR_SPARE, $urandom);

			@(posedge clk);
			case (ph % 4)
				0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin src_idle_pct = 69; rcv_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  rcv_stall_pct = 69; end
				default: begin src_idle_pct = 16; rcv_stall_pct = 16; end
			endcase
			if (ph == PRESSURE_PHASE)
				holdoff_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(4) == 0)
					samples_to_send.push_back(corner_sample($urandom_range(CORNERS - 1)));
				else
					samples_to_send.push_back(tlfo_pkg::SAMPLE_WIDTH'($urandom));
			end
			drain();
		end

		$display("covered %0d samples under %0d register writes, %0d outputs compared",
			items_sent, settings_written, results_checked);
		$display("idle mixes on both channels and a %0d cycle output hold-off; %0d mismatches",
			HOLDOFF_CYCLES, mismatches);
		if (mismatches == 0)
			$display("[tremolo_triangle_lfo] OK");
		else
			$display("[tremolo_triangle_lfo] ERROR");
		$finish;
	end

endmodule

/* sim.f */
src/tlfo_pkg.sv
src/tlfo_regs.sv
src/tlfo_ctrl.sv
src/tlfo_dp.sv
src/tremolo_triangle_lfo.sv
bench/tremolo_triangle_lfo_tb.sv
